### rtl/multi_mode_pid_controller_top_macros.svh
// Assertion macros for the multi-mode PID controller.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MULTI_MODE_PID_CONTROLLER_TOP_MACROS_SVH
`define MULTI_MODE_PID_CONTROLLER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMPID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mmpid_pkg.sv
// Shared types and constants of the multi-mode PID controller.
// No dependencies; used by every module of the block.
`default_nettype none

package mmpid_pkg;

  // Field and register widths.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned SumW     = 32;
  localparam int unsigned GainW    = 16;
  localparam int unsigned DLimW    = 15;
  localparam int unsigned ILimW    = 31;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned FracBits = 8;

  // Operand widths fed to the multipliers.
  localparam int unsigned OpPW = 18;
  localparam int unsigned OpIW = 32;
  localparam int unsigned OpDW = 19;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_DRIVE_LIM  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_INTEG_LIM  = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_LOOP_MODE  = 3'd5;

  // Loop modes; the remaining codes behave as incremental.
  typedef enum logic [ModeW-1:0] {
    MODE_INC      = 3'd0,
    MODE_POS      = 3'd1,
    MODE_TRAP_INC = 3'd2,
    MODE_TRAP_POS = 3'd3,
    MODE_RATE     = 3'd4
  } mode_t;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [DLimW-1:0]        drive_limit;
    logic [ILimW-1:0]        integral_limit;
    logic [ModeW-1:0]        loop_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [OpPW-1:0] op_p;
    logic signed [OpIW-1:0] op_i;
    logic signed [OpDW-1:0] op_d;
  } ops_t;

endpackage

`default_nettype wire

### rtl/mmpid_cfg.sv
// Configuration register file of the multi-mode PID controller.
// Depends on mmpid_pkg.
`default_nettype none

module mmpid_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mmpid_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [mmpid_pkg::CfgDataW-1:0] cfg_wdata,
  output mmpid_pkg::cfg_t                cfg_r
);
  import mmpid_pkg::*;

  cfg_t cfg_nxt;

  // Decode the write; unknown indexes leave everything as it is.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN_P:    cfg_nxt.gain_p         = cfg_wdata[GainW-1:0];
        REG_GAIN_I:    cfg_nxt.gain_i         = cfg_wdata[GainW-1:0];
        REG_GAIN_D:    cfg_nxt.gain_d         = cfg_wdata[GainW-1:0];
        REG_DRIVE_LIM: cfg_nxt.drive_limit    = cfg_wdata[DLimW-1:0];
        REG_INTEG_LIM: cfg_nxt.integral_limit = cfg_wdata[ILimW-1:0];
        REG_LOOP_MODE: cfg_nxt.loop_mode      = cfg_wdata[ModeW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.drive_limit    <= '1;
      cfg_r.integral_limit <= '1;
      cfg_r.loop_mode      <= MODE_INC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mmpid_front.sv
// Error stage: forms the error, keeps the error history and accumulator,
// and selects the three multiplier operands. Depends on mmpid_pkg.
`default_nettype none

module mmpid_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ld,
  input  logic [mmpid_pkg::SampleW-1:0] setpoint,
  input  logic [mmpid_pkg::SampleW-1:0] measurement,
  input  logic [mmpid_pkg::SampleW-1:0] rate,
  input  mmpid_pkg::cfg_t               cfg,
  output mmpid_pkg::ops_t               ops
);
  import mmpid_pkg::*;

  logic signed [ErrW-1:0]  err_prev_r, err_prev_nxt;
  logic signed [ErrW-1:0]  err_prev2_r, err_prev2_nxt;
  logic signed [SumW-1:0]  err_sum_r, err_sum_nxt;

  logic signed [ErrW-1:0]  e0;
  logic signed [ErrW-1:0]  rt;
  logic signed [ErrW:0]    d01;
  logic signed [ErrW:0]    pair_sum;
  logic signed [ErrW-1:0]  half;
  logic signed [ErrW+1:0]  d2;
  logic signed [ErrW-1:0]  incr;
  logic                    upd;
  logic                    shift_hist;
  logic signed [SumW:0]    sum_raw;
  logic signed [SumW:0]    lim_pos;
  logic signed [SumW:0]    lim_neg;
  logic signed [SumW-1:0]  sum_clamped;

  // Error terms from the current sample and the history.
  always_comb begin
    e0       = $signed({setpoint[SampleW-1], setpoint})
             - $signed({measurement[SampleW-1], measurement});
    rt       = $signed({rate[SampleW-1], rate});
    d01      = $signed({e0[ErrW-1], e0}) - $signed({err_prev_r[ErrW-1], err_prev_r});
    pair_sum = $signed({e0[ErrW-1], e0}) + $signed({err_prev_r[ErrW-1], err_prev_r});
    half     = pair_sum[ErrW:1];
    d2       = $signed({{2{e0[ErrW-1]}}, e0})
             - $signed({err_prev_r[ErrW-1], err_prev_r, 1'b0})
             + $signed({{2{err_prev2_r[ErrW-1]}}, err_prev2_r});
  end

  // Accumulator increment and clamp.
  always_comb begin
    incr       = '0;
    upd        = 1'b0;
    shift_hist = 1'b1;
    case (cfg.loop_mode)
      MODE_POS: begin
        incr = e0;
        upd  = 1'b1;
      end
      MODE_TRAP_POS: begin
        incr = half;
        upd  = 1'b1;
      end
      MODE_RATE: begin
        incr       = rt;
        upd        = (cfg.gain_i != '0);
        shift_hist = 1'b0;
      end
      default: begin
        incr = '0;
        upd  = 1'b0;
      end
    endcase

    sum_raw = $signed({err_sum_r[SumW-1], err_sum_r})
            + $signed({{(SumW-ErrW+1){incr[ErrW-1]}}, incr});
    lim_pos = $signed({2'b00, cfg.integral_limit});
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      sum_clamped = lim_pos[SumW-1:0];
    end else if (sum_raw < lim_neg) begin
      sum_clamped = lim_neg[SumW-1:0];
    end else begin
      sum_clamped = sum_raw[SumW-1:0];
    end

    err_sum_nxt   = upd ? sum_clamped : err_sum_r;
    err_prev_nxt  = shift_hist ? e0 : err_prev_r;
    err_prev2_nxt = shift_hist ? err_prev_r : err_prev2_r;
  end

  // Operand selection per mode.
  always_comb begin
    case (cfg.loop_mode)
      MODE_POS, MODE_TRAP_POS: begin
        ops.op_p = $signed({e0[ErrW-1], e0});
        ops.op_i = err_sum_nxt;
        ops.op_d = $signed({d01[ErrW], d01});
      end
      MODE_RATE: begin
        ops.op_p = $signed({e0[ErrW-1], e0});
        ops.op_i = err_sum_nxt;
        ops.op_d = -$signed({{2{rt[ErrW-1]}}, rt});
      end
      MODE_TRAP_INC: begin
        ops.op_p = d01;
        ops.op_i = $signed({{(SumW-ErrW){half[ErrW-1]}}, half});
        ops.op_d = d2;
      end
      default: begin
        ops.op_p = d01;
        ops.op_i = $signed({{(SumW-ErrW){e0[ErrW-1]}}, e0});
        ops.op_d = d2;
      end
    endcase
  end

  // History and accumulator move once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_prev_r  <= '0;
      err_prev2_r <= '0;
      err_sum_r   <= '0;
    end else if (ld) begin
      err_prev_r  <= err_prev_nxt;
      err_prev2_r <= err_prev2_nxt;
      err_sum_r   <= err_sum_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mmpid_mac.sv
// Multiply and output stage: three gain products, then sum, floor shift
// and drive saturation into the result register. Depends on mmpid_pkg.
`default_nettype none

module mmpid_mac (
  input  logic                          clk,
  input  logic                          ld,
  input  mmpid_pkg::ops_t               ops,
  input  mmpid_pkg::cfg_t               cfg,
  output logic [mmpid_pkg::SampleW-1:0] drive_r
);
  import mmpid_pkg::*;

  localparam int unsigned PPW = GainW + OpPW;
  localparam int unsigned PIW = GainW + OpIW;
  localparam int unsigned PDW = GainW + OpDW;
  localparam int unsigned AccW = PIW + 2;
  localparam int unsigned ShW  = AccW - FracBits;

  logic signed [PPW-1:0] prod_p;
  logic signed [PIW-1:0] prod_i;
  logic signed [PDW-1:0] prod_d;
  logic [SampleW-1:0]    drive_nxt;

  logic signed [AccW-1:0] acc;
  logic signed [ShW-1:0]  acc_sh;
  logic signed [ShW-1:0]  lim_pos;
  logic signed [ShW-1:0]  lim_neg;
  logic signed [ShW-1:0]  sat;

  // Gain products.
  always_comb begin
    prod_p = cfg.gain_p * ops.op_p;
    prod_i = cfg.gain_i * ops.op_i;
    prod_d = cfg.gain_d * ops.op_d;
  end

  // Exact sum, floor by the fraction bits, then saturate.
  always_comb begin
    acc = $signed({{(AccW-PPW){prod_p[PPW-1]}}, prod_p})
        + $signed({{(AccW-PIW){prod_i[PIW-1]}}, prod_i})
        + $signed({{(AccW-PDW){prod_d[PDW-1]}}, prod_d});
    acc_sh  = acc[AccW-1:FracBits];
    lim_pos = $signed({{(ShW-DLimW){1'b0}}, cfg.drive_limit});
    lim_neg = -lim_pos;
    if (acc_sh > lim_pos) begin
      sat = lim_pos;
    end else if (acc_sh < lim_neg) begin
      sat = lim_neg;
    end else begin
      sat = acc_sh;
    end
    drive_nxt = sat[SampleW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      drive_r <= drive_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/multi_mode_pid_controller_top.sv
// Multi-mode PID controller, top level: input register, configuration, error
// stage and multiply/output stage. Depends on mmpid_pkg.
// An accepted item waits in the input register until the result register is free,
// then loads; out_tvalid rises in the cycle after the load. Throughput: one item
// per cycle while out_tready is high; in_tready is low only while both are full.
// Reset (synchronous) clears the valids, the history and the accumulator.
`default_nettype none

module multi_mode_pid_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [mmpid_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [mmpid_pkg::CfgDataW-1:0] cfg_wdata,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,  // setpoint, measurement, rate
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata  // drive
);
  import mmpid_pkg::*;

  `include "multi_mode_pid_controller_top_macros.svh"

  cfg_t cfg;
  ops_t ops;

  logic [SampleW-1:0] sp_r, ms_r, rt_r;
  logic s0_valid_r, s0_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_acc, ld;

  // The input register moves into the result register when that one is free.
  always_comb begin
    ld        = s0_valid_r && (!out_valid_r || out_tready);
    in_tready = !s0_valid_r || ld;
    in_acc    = in_tvalid && in_tready;

    s0_valid_nxt  = in_acc ? 1'b1 : (ld ? 1'b0 : s0_valid_r);
    out_valid_nxt = ld ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sp_r <= in_tdata[15:0];
      ms_r <= in_tdata[31:16];
      rt_r <= in_tdata[47:32];
    end
  end

  mmpid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg)
  );

  mmpid_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (ld),
    .setpoint    (sp_r),
    .measurement (ms_r),
    .rate        (rt_r),
    .cfg         (cfg),
    .ops         (ops)
  );

  mmpid_mac u_mac (
    .clk     (clk),
    .ld      (ld),
    .ops     (ops),
    .cfg     (cfg),
    .drive_r (out_tdata)
  );

  assign out_tvalid = out_valid_r;

  // Stage control checks.
  `MMPID_ASSERT_NEXT(a_in_captured, in_acc, s0_valid_r, "accepted item not held in input stage")
  `MMPID_ASSERT_SAME(a_ready_when_empty, !s0_valid_r, in_tready, "input stage empty but not ready")
  `MMPID_ASSERT_NEXT(a_out_loaded, ld, out_tvalid, "result load did not raise out_tvalid")
  `MMPID_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, $stable(out_tdata), "result not held")

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-mode PID controller top level.
// Drives samples and register writes, predicts every drive value and compares
// it with the result stream. Depends on mmpid_pkg and the controller RTL.

module tb_top;
  import mmpid_pkg::*;

  // Mode codes with no mode of their own; they run as incremental.
  localparam logic [ModeW-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_7 = 3'd7;
  // Register indexes with no register behind them.
  localparam logic [CfgAddrW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_SPARE_7 = 3'd7;

  localparam int RandPhases     = 12;
  localparam int ItemsPerPhase  = 85;
  localparam int MaxPrinted     = 40;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CfgAddrW-1:0]    addr;
    logic [CfgDataW-1:0]    data;
    logic [SampleW-1:0]     setpoint;
    logic [SampleW-1:0]     measurement;
    logic [SampleW-1:0]     rate;
    bit                     has_drive;
    logic [SampleW-1:0]     drive;
  } stim_row_t;

  typedef struct {
    logic [SampleW-1:0] drive;
    int unsigned        sample_no;
  } drive_rec_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [47:0]         in_tdata;   // setpoint, measurement, rate
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;  // drive

  // Typed-in drive value that travels beside the item being offered.
  bit                 row_has_drive;
  logic [SampleW-1:0] row_drive;

  // Register copies and loop state of the predictor.
  logic signed [GainW-1:0] gain_p_r;
  logic signed [GainW-1:0] gain_i_r;
  logic signed [GainW-1:0] gain_d_r;
  logic [DLimW-1:0]        drive_lim_r;
  logic [ILimW-1:0]        integ_lim_r;
  logic [ModeW-1:0]        mode_r;
  logic signed [ErrW-1:0]  err_d1;
  logic signed [ErrW-1:0]  err_d2;
  logic signed [SumW-1:0]  err_sum;

  drive_rec_t  pending_drives[$];
  stim_row_t   stim_rows[$];
  int unsigned sample_count;
  int unsigned fail_count;
  int          burst_left;
  bit          sender_idles;

  multi_mode_pid_controller_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint clamp_sym(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Drive value for one sample; advances the history and the accumulator.
  function automatic logic [SampleW-1:0] pid_predict_drive(
    input logic signed [SampleW-1:0] sp,
    input logic signed [SampleW-1:0] ms,
    input logic signed [SampleW-1:0] rt
  );
    longint e0, e1, e2, acc, sum, gp, gi, gd;
    bit     shift_hist;
    e0 = longint'(sp) - longint'(ms);
    e1 = longint'(err_d1);
    e2 = longint'(err_d2);
    sum = longint'(err_sum);
    gp = longint'(gain_p_r);
    gi = longint'(gain_i_r);
    gd = longint'(gain_d_r);
    shift_hist = 1'b1;
    case (mode_r)
      MODE_POS: begin
        sum = clamp_sym(sum + e0, longint'(integ_lim_r));
        acc = gp * e0 + gi * sum + gd * (e0 - e1);
      end
      MODE_TRAP_INC: begin
        acc = gp * (e0 - e1) + gi * ((e0 + e1) >>> 1) + gd * (e0 - 2 * e1 + e2);
      end
      MODE_TRAP_POS: begin
        sum = clamp_sym(sum + ((e0 + e1) >>> 1), longint'(integ_lim_r));
        acc = gp * e0 + gi * sum + gd * (e0 - e1);
      end
      MODE_RATE: begin
        acc = gp * e0 - gd * longint'(rt);
        // The rate only integrates while an integral gain is set.
        if (gi != 0) begin
          sum = clamp_sym(sum + longint'(rt), longint'(integ_lim_r));
          acc = acc + gi * sum;
        end
        shift_hist = 1'b0;
      end
      default: begin
        acc = gp * (e0 - e1) + gi * e0 + gd * (e0 - 2 * e1 + e2);
      end
    endcase
    err_sum = sum[SumW-1:0];
    if (shift_hist) begin
      err_d2 = err_d1;
      err_d1 = e0[ErrW-1:0];
    end
    acc = clamp_sym(acc >>> FracBits, longint'(drive_lim_r));
    return acc[SampleW-1:0];
  endfunction

  // Register write as the block sees it; unknown indexes are dropped.
  function automatic void apply_reg_write(input logic [CfgAddrW-1:0] addr,
                                          input logic [CfgDataW-1:0] data);
    case (addr)
      REG_GAIN_P:    gain_p_r = data[GainW-1:0];
      REG_GAIN_I:    gain_i_r = data[GainW-1:0];
      REG_GAIN_D:    gain_d_r = data[GainW-1:0];
      REG_DRIVE_LIM: drive_lim_r = data[DLimW-1:0];
      REG_INTEG_LIM: integ_lim_r = data[ILimW-1:0];
      REG_LOOP_MODE: mode_r = data[ModeW-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned no,
                                 input logic [SampleW-1:0] want,
                                 input logic [SampleW-1:0] got);
    if (fail_count < MaxPrinted)
      $display("MISMATCH %s: sample %0d drive expected %h got %h at %0t",
               what, no, want, got, $realtime);
    fail_count++;
  endtask

  // Predictor and checker, both handshakes seen at the same rising edge.
  always @(posedge clk) begin : drive_checker
    drive_rec_t rec;
    if (!rst_n) begin
      gain_p_r = '0;
      gain_i_r = '0;
      gain_d_r = '0;
      drive_lim_r = 15'h7FFF;
      integ_lim_r = 31'h7FFF_FFFF;
      mode_r = MODE_INC;
      err_d1 = '0;
      err_d2 = '0;
      err_sum = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_drives.size() == 0) begin
          report_mismatch("unexpected item", 0, 'x, out_tdata);
        end else begin
          rec = pending_drives.pop_front();
          if (out_tdata !== rec.drive)
            report_mismatch("drive", rec.sample_no, rec.drive, out_tdata);
        end
      end
      if (in_tvalid && in_tready) begin
        rec.drive = pid_predict_drive(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
        if (row_has_drive) rec.drive = row_drive;
        rec.sample_no = sample_count;
        pending_drives.push_back(rec);
        sample_count++;
      end
      if (cfg_we) apply_reg_write(cfg_addr, cfg_wdata);
    end
  end

  // Receiver stalls follow a bit pattern that changes every so often.
  always @(negedge clk) begin : ready_pattern
    static int          pat_left = 0;
    static logic [15:0] pat = '1;
    static logic [3:0]  pat_idx = '0;
    if (pat_left == 0) begin
      pat_left = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       pat = '1;
        1:       pat = 16'($urandom & $urandom) | 16'h0001;
        default: pat = 16'($urandom) | 16'h0001;
      endcase
    end
    out_tready = pat[pat_idx];
    pat_idx++;
    pat_left--;
  end

  task automatic add_write(input logic [CfgAddrW-1:0] addr, input int data);
    stim_row_t r;
    r = '{kind: ROW_WRITE, default: '0};
    r.addr = addr;
    r.data = CfgDataW'(data);
    stim_rows.push_back(r);
  endtask

  task automatic add_sample(input int sp, input int ms, input int rt,
                            input bit has_drive = 1'b0, input int drive = 0);
    stim_row_t r;
    r = '{kind: ROW_SAMPLE, default: '0};
    r.setpoint = SampleW'(sp);
    r.measurement = SampleW'(ms);
    r.rate = SampleW'(rt);
    r.has_drive = has_drive;
    r.drive = SampleW'(drive);
    stim_rows.push_back(r);
  endtask

  // Offer one item, with the sender idling between bursts.
  task automatic send_sample(input logic [SampleW-1:0] sp, input logic [SampleW-1:0] ms,
                             input logic [SampleW-1:0] rt, input bit has_drive,
                             input logic [SampleW-1:0] drive);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_idles) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {rt, ms, sp};
    row_has_drive = has_drive;
    row_drive = drive;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering items and let every outstanding result come out.
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [SampleW-1:0] rand_sample_field();
    case ($urandom_range(0, 9))
      0:             return 16'h8000;
      1:             return 16'h7FFF;
      2:             return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      3, 4, 5, 6:    return SampleW'(int'($urandom_range(0, 600)) - 300);
      default:       return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0:             return CfgDataW'(16'h8000);
      1:             return CfgDataW'(16'h7FFF);
      2:             return '0;
      3, 4, 5, 6:    return CfgDataW'(SampleW'(int'($urandom_range(0, 1024)) - 512));
      default:       return CfgDataW'($urandom);
    endcase
  endfunction

  // Directed rows: reset values, extremes, every mode and the special cases.
  task automatic build_directed_rows();
    add_sample(100, 50, 0, 1'b1, 0);
    add_sample(-32768, 32767, 32767, 1'b1, 0);
    add_write(REG_GAIN_P, 256);
    add_write(REG_LOOP_MODE, MODE_POS);
    add_sample(32767, -32768, 0, 1'b1, 32767);
    add_sample(-32768, 32767, 0, 1'b1, -32767);
    // A zero drive limit pins the output to zero.
    add_write(REG_DRIVE_LIM, 0);
    add_sample(1000, 0, 0, 1'b1, 0);
    add_write(REG_DRIVE_LIM, 32767);
    // The shift floors, so a tiny negative sum gives minus one.
    add_write(REG_GAIN_P, 1);
    add_sample(-1, 0, 0, 1'b1, -1);
    add_sample(1, 0, 0, 1'b1, 0);
    add_write(REG_GAIN_P, -32768);
    add_write(REG_GAIN_I, 32767);
    add_write(REG_GAIN_D, -32768);
    add_write(REG_LOOP_MODE, MODE_INC);
    add_sample(32767, -32768, -32768);
    add_sample(-32768, 32767, 0);
    add_sample(0, 0, 0);
    add_write(REG_LOOP_MODE, MODE_TRAP_INC);
    add_sample(12345, -3, 7);
    add_sample(-7, 6, 0);
    // A zero integral limit keeps the accumulator at zero.
    add_write(REG_INTEG_LIM, 0);
    add_write(REG_GAIN_I, 100);
    add_write(REG_LOOP_MODE, MODE_POS);
    add_sample(5000, -5000, 0);
    add_write(REG_INTEG_LIM, 1000);
    add_write(REG_LOOP_MODE, MODE_TRAP_POS);
    add_sample(32767, -32768, 0);
    add_sample(-32768, 32767, 0);
    add_sample(-3, 0, 0);
    // Rate mode holds the history; the rate integrates only with a gain.
    add_write(REG_LOOP_MODE, MODE_RATE);
    add_sample(100, 0, -32768);
    add_sample(-100, 0, 32767);
    add_write(REG_GAIN_I, 0);
    add_sample(100, 0, 500);
    // Spare mode codes fall back to incremental.
    add_write(REG_GAIN_I, 300);
    add_write(REG_LOOP_MODE, MODE_SPARE_5);
    add_sample(2000, -1000, 0);
    add_write(REG_LOOP_MODE, MODE_SPARE_6);
    add_sample(-2000, 1000, 0);
    add_write(REG_LOOP_MODE, MODE_SPARE_7);
    add_sample(32767, 32767, 0);
    // Writes to unused indexes must change nothing.
    add_write(REG_SPARE_6, 31'h7FFF_FFFF);
    add_write(REG_SPARE_7, 31'h7FFF_FFFF);
    add_sample(-500, 400, 300);
  endtask

  initial begin : stimulus
    stim_row_t          r;
    bit                 last_was_sample;
    logic [CfgDataW-1:0] lim;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    row_has_drive = 1'b0;
    row_drive = '0;
    sample_count = 0;
    fail_count = 0;
    burst_left = 0;
    sender_idles = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table; writes wait until the block is idle.
    build_directed_rows();
    last_was_sample = 1'b0;
    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      if (r.kind == ROW_WRITE) begin
        if (last_was_sample) drain_pipeline();
        write_reg(r.addr, r.data);
        last_was_sample = 1'b0;
      end else begin
        send_sample(r.setpoint, r.measurement, r.rate, r.has_drive, r.drive);
        last_was_sample = 1'b1;
      end
    end

    // Random phases, each with a fresh setting of every register.
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_pipeline();
      sender_idles = ($urandom_range(0, 3) != 0);
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, rand_gain());
      write_reg(REG_GAIN_D, rand_gain());
      case ($urandom_range(0, 5))
        0:       lim = '0;
        1:       lim = CfgDataW'(15'h7FFF);
        default: lim = CfgDataW'($urandom_range(0, 32767));
      endcase
      write_reg(REG_DRIVE_LIM, lim);
      case ($urandom_range(0, 7))
        0:          lim = '0;
        1:          lim = 31'h7FFF_FFFF;
        2, 3, 4:    lim = CfgDataW'($urandom_range(0, 5000));
        default:    lim = CfgDataW'($urandom);
      endcase
      write_reg(REG_INTEG_LIM, lim);
      write_reg(REG_LOOP_MODE, (ph < 8) ? CfgDataW'(ph) : CfgDataW'($urandom_range(0, 7)));
      for (int n = 0; n < ItemsPerPhase; n++)
        send_sample(rand_sample_field(), rand_sample_field(), rand_sample_field(), 1'b0, '0);
    end

    drain_pipeline();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/mmpid_pkg.sv
rtl/mmpid_cfg.sv
rtl/mmpid_front.sv
rtl/mmpid_mac.sv
rtl/multi_mode_pid_controller_top.sv
sim/tb_top.sv
